// ===== design/lbr_pkg.sv =====
// lbr_pkg: request kinds and fixed field widths for the box reorder list
// no dependencies
`timescale 1ns / 1ps

package lbr_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned LABEL_W = 11;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    REQ_INIT    = 3'd0,
    REQ_LEFT    = 3'd1,
    REQ_RIGHT   = 3'd2,
    REQ_SWAP    = 3'd3,
    REQ_REVERSE = 3'd4,
    REQ_REPORT  = 3'd5
  } req_kind_e;

endpackage

// ===== design/lbr_link_ram.sv =====
// lbr_link_ram: one link table, single write port, single registered read port
// no dependencies
`timescale 1ns / 1ps

module lbr_link_ram #(
  parameter int unsigned DEPTH = 1025,
  parameter int unsigned WIDTH = 11
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/linked_list_box_reorder.sv =====
// linked_list_box_reorder: circular doubly linked box list in two link tables
// depends on lbr_pkg and lbr_link_ram
`timescale 1ns / 1ps
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: req_type; tdata: box_a, box_b
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: odd_sum
// cfg       in   cfg_we_i                      cfg_wdata_i: box_count
//
// reverse and rejected requests finish in the idle state; moves and swaps make two link
// reads, then write one join per cycle, or write none when the move is already in place.
// init writes N+1 entries, report reads N: one entry a cycle through the single port of
// each link table.
// the link tables have no reset and no clearing pass; init must come first.
// a finished report waits in the output register while new requests are taken;
// a later report holds in its last cycle until that word is taken.

module linked_list_box_reorder
  import lbr_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // box_a, box_b, zero pad
  input  logic [KIND_W-1:0]   s_axis_tuser,  // req_type
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata   // odd_sum, zero pad
);

  localparam int unsigned DEPTH = MAX_BOXES + 1;
  localparam int unsigned LW = $clog2(DEPTH);
  localparam int unsigned PW = 2 * LW + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDB, ST_RDA, ST_CALC, ST_JOIN, ST_INIT, ST_WSTART, ST_WALK, ST_FIN
  } state_e;

  state_e            state_q;
  logic [COUNT_W-1:0] box_count_q;
  logic              rev_q;
  req_kind_e         kind_q;
  logic [LW-1:0]     a_q, b_q, n_q, lb_q, rb_q, cnt_q;
  logic [LW-1:0]     jl_q [4];
  logic [LW-1:0]     jr_q [4];
  logic [1:0]        jleft_q;
  logic [SUM_W-1:0]  sum_q, total_q, odd_sum_q;
  logic              m_valid_q;

  logic              r_we, l_we;
  logic [LW-1:0]     r_waddr, r_wdata, r_raddr, r_rdata;
  logic [LW-1:0]     l_waddr, l_wdata, l_raddr, l_rdata;

  logic [LW-1:0]     n_cur;
  req_kind_e         in_kind;
  logic [LABEL_W-1:0] in_a, in_b;
  logic              labels_ok;

  logic              swp, skip;
  logic [LW-1:0]     ea, eb, ela, era, elb, erb;
  req_kind_e         ek;
  logic [LW-1:0]     cl [4];
  logic [LW-1:0]     cr [4];
  logic [1:0]        clast;
  logic [PW-1:0]     prod;

  assign in_kind = req_kind_e'(s_axis_tuser);
  assign in_a    = s_axis_tdata[LABEL_W-1:0];
  assign in_b    = s_axis_tdata[2*LABEL_W-1:LABEL_W];

  always_comb begin
    if (box_count_q == '0) begin
      n_cur = LW'(1);
    end else if (32'(box_count_q) > MAX_BOXES) begin
      n_cur = LW'(MAX_BOXES);
    end else begin
      n_cur = LW'(box_count_q);
    end
  end

  assign labels_ok = (in_a != '0) && (32'(in_a) <= 32'(n_cur)) &&
                     (in_b != '0) && (32'(in_b) <= 32'(n_cur)) && (in_a != in_b);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_DATA_W'(odd_sum_q);

  // boxes as seen after an adjacent swap is turned round, the move side after a reverse, and the joins to write
  always_comb begin
    swp = (kind_q == REQ_SWAP) && (rb_q == a_q);
    ea  = swp ? b_q : a_q;
    eb  = swp ? a_q : b_q;
    ela = swp ? lb_q : l_rdata;
    era = swp ? rb_q : r_rdata;
    elb = swp ? l_rdata : lb_q;
    erb = swp ? r_rdata : rb_q;
    ek  = kind_q;
    if (kind_q != REQ_SWAP && rev_q) begin
      ek = (kind_q == REQ_LEFT) ? REQ_RIGHT : REQ_LEFT;
    end
    skip = ((ek == REQ_LEFT) && (ea == elb)) || ((ek == REQ_RIGHT) && (ea == erb));
    cl[0] = ela;
    cr[0] = era;
    cl[1] = elb;
    cr[1] = ea;
    cl[2] = ea;
    cr[2] = eb;
    cl[3] = ea;
    cr[3] = erb;
    clast = 2'd2;
    case (ek)
      REQ_LEFT: begin
      end
      REQ_RIGHT: begin
        cl[1] = eb;
        cr[1] = ea;
        cl[2] = ea;
        cr[2] = erb;
      end
      REQ_SWAP: begin
        cr[0] = eb;
        if (era == eb) begin
          cl[1] = eb;
          cr[1] = ea;
          cl[2] = ea;
          cr[2] = erb;
        end else begin
          cl[1] = eb;
          cr[1] = era;
          cl[2] = elb;
          cr[2] = ea;
          clast = 2'd3;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    r_we    = 1'b0;
    l_we    = 1'b0;
    r_waddr = jl_q[0];
    r_wdata = jr_q[0];
    l_waddr = jr_q[0];
    l_wdata = jl_q[0];
    r_raddr = b_q;
    l_raddr = b_q;
    case (state_q)
      ST_RDA: begin
        r_raddr = a_q;
        l_raddr = a_q;
      end
      ST_JOIN: begin
        r_we = 1'b1;
        l_we = 1'b1;
      end
      ST_INIT: begin
        r_we    = 1'b1;
        l_we    = 1'b1;
        r_waddr = cnt_q;
        l_waddr = cnt_q;
        if (cnt_q == '0) begin
          r_wdata = LW'(1);
          l_wdata = n_q;
        end else begin
          r_wdata = (cnt_q == n_q) ? '0 : cnt_q + LW'(1);
          l_wdata = cnt_q - LW'(1);
        end
      end
      ST_WSTART: r_raddr = '0;
      ST_WALK:   r_raddr = r_rdata;
      default: begin
      end
    endcase
  end

  assign prod = PW'(n_q) * (PW'(n_q) + PW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      box_count_q <= COUNT_RESET;
      rev_q       <= 1'b0;
      m_valid_q   <= 1'b0;
      kind_q      <= REQ_INIT;
      a_q         <= '0;
      b_q         <= '0;
      n_q         <= '0;
      lb_q        <= '0;
      rb_q        <= '0;
      cnt_q       <= '0;
      jleft_q     <= '0;
      sum_q       <= '0;
      total_q     <= '0;
      odd_sum_q   <= '0;
      for (int k = 0; k < 4; k++) begin
        jl_q[k] <= '0;
        jr_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        box_count_q <= cfg_wdata_i;
      end
      if (m_valid_q && m_axis_tready && state_q != ST_FIN) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q <= in_kind;
            a_q    <= LW'(in_a);
            b_q    <= LW'(in_b);
            n_q    <= n_cur;
            cnt_q  <= '0;
            case (in_kind)
              REQ_INIT:    state_q <= ST_INIT;
              REQ_REVERSE: rev_q <= !rev_q;
              REQ_REPORT:  state_q <= ST_WSTART;
              REQ_LEFT, REQ_RIGHT, REQ_SWAP: begin
                if (labels_ok) begin
                  state_q <= ST_RDB;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RDB: state_q <= ST_RDA;
        ST_RDA: begin
          lb_q    <= l_rdata;
          rb_q    <= r_rdata;
          state_q <= ST_CALC;
        end
        ST_CALC: begin
          for (int k = 0; k < 4; k++) begin
            jl_q[k] <= cl[k];
            jr_q[k] <= cr[k];
          end
          jleft_q <= clast;
          state_q <= skip ? ST_IDLE : ST_JOIN;
        end
        ST_JOIN: begin
          for (int k = 0; k < 3; k++) begin
            jl_q[k] <= jl_q[k+1];
            jr_q[k] <= jr_q[k+1];
          end
          jleft_q <= jleft_q - 2'd1;
          if (jleft_q == 2'd0) begin
            state_q <= ST_IDLE;
          end
        end
        ST_INIT: begin
          rev_q <= 1'b0;
          cnt_q <= cnt_q + LW'(1);
          if (cnt_q == n_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_WSTART: begin
          total_q <= SUM_W'(prod >> 1);
          sum_q   <= '0;
          cnt_q   <= LW'(1);
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (cnt_q[0]) begin
            sum_q <= sum_q + SUM_W'(r_rdata);
          end
          cnt_q <= cnt_q + LW'(1);
          if (cnt_q == n_q) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            odd_sum_q <= (rev_q && !n_q[0]) ? total_q - sum_q : sum_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  lbr_link_ram #(
    .DEPTH(DEPTH),
    .WIDTH(LW)
  ) u_right_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  lbr_link_ram #(
    .DEPTH(DEPTH),
    .WIDTH(LW)
  ) u_left_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  a_result_from_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN))
    else $error("result raised outside report completion");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q != '0) && (cnt_q <= n_q))
    else $error("walk counter beyond box count");

  a_init_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (cnt_q <= n_q) && (n_q != '0))
    else $error("init write beyond box count");

  a_report_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && m_valid_q && !m_axis_tready |=> (state_q == ST_FIN))
    else $error("report overwrote a pending result");

endmodule

// ===== dv/lbr_list_checker.sv =====
`timescale 1ns / 1ps
// lbr_list_checker: watches the request, result and register ports of the box list,
// keeps its own copy of the link tables and checks every odd_sum word in order
// depends on lbr_pkg

module lbr_list_checker
  import lbr_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // box_a, box_b, zero pad
  input  logic [KIND_W-1:0]   s_axis_tuser,  // req_type
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,  // odd_sum, zero pad
  input  logic                final_check_i,
  output int                  err_count_o
);

  logic [LABEL_W-1:0] right_lk [0:MAX_BOXES];
  logic [LABEL_W-1:0] left_lk  [0:MAX_BOXES];
  logic               flipped;
  logic [COUNT_W-1:0] count_reg;
  logic [SUM_W-1:0]   sums_due [$];
  int                 errors;

  logic [KIND_W-1:0]  req_kind;
  int unsigned        lab_a;
  int unsigned        lab_b;
  logic [SUM_W-1:0]   got_sum;
  logic [SUM_W-1:0]   want_sum;

  assign err_count_o = errors;

  // entries never written by an init read as zero
  initial begin
    errors = 0;
    for (int i = 0; i <= MAX_BOXES; i++) begin
      right_lk[i] = '0;
      left_lk[i]  = '0;
    end
  end

  function automatic int unsigned live_count();
    int unsigned n;
    n = 32'(count_reg);
    if (n < 1) n = 1;
    if (n > MAX_BOXES) n = MAX_BOXES;
    return n;
  endfunction

  function automatic void tie_links(input int unsigned l, input int unsigned r);
    if (l <= MAX_BOXES) right_lk[l] = LABEL_W'(r);
    if (r <= MAX_BOXES) left_lk[r] = LABEL_W'(l);
  endfunction

  function automatic void restore_order();
    int unsigned n;
    n = live_count();
    for (int unsigned i = 1; i <= n; i++) begin
      left_lk[i]  = LABEL_W'(i - 1);
      right_lk[i] = (i == n) ? '0 : LABEL_W'(i + 1);
    end
    right_lk[0] = LABEL_W'(1);
    left_lk[0]  = LABEL_W'(n);
    flipped     = 1'b0;
  endfunction

  function automatic logic [SUM_W-1:0] odd_position_sum();
    int unsigned     n;
    int unsigned     cur;
    longint unsigned sum;
    n   = live_count();
    cur = 0;
    sum = 0;
    for (int unsigned j = 1; j <= n; j++) begin
      cur = 32'(right_lk[cur]);
      if (j[0]) sum += 64'(cur);
    end
    // seen backwards with an even count, odd positions become the even ones
    if (flipped && !n[0]) sum = 64'((n * (n + 1)) / 2) - sum;
    return sum[SUM_W-1:0];
  endfunction

  function automatic void move_or_swap(input logic [KIND_W-1:0] kind_in,
                                       input int unsigned a_in, input int unsigned b_in);
    logic [KIND_W-1:0] kind;
    int unsigned a, b, n, la, ra, lb, rb;
    kind = kind_in;
    a    = a_in;
    b    = b_in;
    n    = live_count();
    if (a == 0 || a > n || b == 0 || b > n || a == b) return;
    if (kind == REQ_SWAP && 32'(right_lk[b]) == a) begin
      a = b_in;
      b = a_in;
    end
    if (kind != REQ_SWAP && flipped) kind = (kind == REQ_LEFT) ? REQ_RIGHT : REQ_LEFT;
    if (kind == REQ_LEFT && 32'(left_lk[b]) == a) return;
    if (kind == REQ_RIGHT && 32'(right_lk[b]) == a) return;
    la = 32'(left_lk[a]);
    ra = 32'(right_lk[a]);
    lb = 32'(left_lk[b]);
    rb = 32'(right_lk[b]);
    case (kind)
      REQ_LEFT: begin
        tie_links(la, ra);
        tie_links(lb, a);
        tie_links(a, b);
      end
      REQ_RIGHT: begin
        tie_links(la, ra);
        tie_links(b, a);
        tie_links(a, rb);
      end
      default: begin
        if (ra == b) begin
          tie_links(la, b);
          tie_links(b, a);
          tie_links(a, rb);
        end else begin
          tie_links(la, b);
          tie_links(b, ra);
          tie_links(lb, a);
          tie_links(a, rb);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      flipped   = 1'b0;
      count_reg = COUNT_RESET;
      sums_due.delete();
    end else begin
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        req_kind = s_axis_tuser;
        lab_a    = 32'(s_axis_tdata[LABEL_W-1:0]);
        lab_b    = 32'(s_axis_tdata[2*LABEL_W-1:LABEL_W]);
        case (req_kind)
          REQ_INIT:                     restore_order();
          REQ_REVERSE:                  flipped = !flipped;
          REQ_REPORT:                   sums_due.push_back(odd_position_sum());
          REQ_LEFT, REQ_RIGHT, REQ_SWAP: move_or_swap(req_kind, lab_a, lab_b);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_sum = m_axis_tdata[SUM_W-1:0];
        if (sums_due.size() == 0) begin
          $error("odd_sum: no word expected, actual %0d", got_sum);
          errors++;
        end else begin
          want_sum = sums_due.pop_front();
          if (got_sum != want_sum) begin
            $error("odd_sum: expected %0d, actual %0d", want_sum, got_sum);
            errors++;
          end
        end
      end
      if (final_check_i && sums_due.size() != 0) begin
        $error("odd_sum: %0d expected words never arrived", sums_due.size());
        errors++;
        sums_due.delete();
      end
    end
  end

endmodule

// ===== dv/linked_list_box_reorder_tb.sv =====
`timescale 1ns / 1ps
// linked_list_box_reorder_tb: drives list requests and box counts into the box list,
// varies idling on both streams and gives the verdict
// depends on lbr_pkg, linked_list_box_reorder and lbr_list_checker

module linked_list_box_reorder_tb;
  import lbr_pkg::*;

  localparam int unsigned MAX_BOXES   = 1024;
  localparam int unsigned LABEL_MAX   = (1 << LABEL_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = MAX_BOXES + 16;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [COUNT_W-1:0]  cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata;   // box_a, box_b, zero pad
  logic [KIND_W-1:0]   s_axis_tuser;   // req_type
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;   // odd_sum, zero pad
  logic                final_check;
  int                  fail_count;

  int          tx_idle_pct;
  int          rx_stall_pct;
  int          rx_hold_req;
  int          hold_left;
  int unsigned reports_sent;
  int unsigned results_seen;
  int unsigned eff_n;
  int unsigned inited_upto;
  int unsigned cycle_count;

  linked_list_box_reorder #(
    .MAX_BOXES(MAX_BOXES)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  lbr_list_checker #(
    .MAX_BOXES(MAX_BOXES)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .final_check_i(final_check),
    .err_count_o  (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("linked_list_box_reorder_tb: errors");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) results_seen++;
    if (rx_hold_req > 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic logic [LABEL_W-1:0] any_label();
    return LABEL_W'($urandom_range(0, LABEL_MAX));
  endfunction

  // labels the link tables already hold
  function automatic logic [LABEL_W-1:0] good_label();
    int unsigned lim;
    lim = (eff_n < inited_upto) ? eff_n : inited_upto;
    return LABEL_W'($urandom_range(1, lim));
  endfunction

  function automatic logic [LABEL_W-1:0] bad_label();
    if ($urandom_range(0, 3) == 0) return '0;
    return LABEL_W'($urandom_range(eff_n + 1, LABEL_MAX));
  endfunction

  task automatic push_req(input logic [KIND_W-1:0] kind, input logic [LABEL_W-1:0] a,
                          input logic [LABEL_W-1:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(S_DATA_W - 2 * LABEL_W){1'b0}}, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == REQ_REPORT) reports_sent++;
    if (kind == REQ_INIT && eff_n > inited_upto) inited_upto = eff_n;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (results_seen < reports_sent) @(posedge clk_i);
  endtask

  task automatic set_count(input logic [COUNT_W-1:0] count);
    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    eff_n = (count < 1) ? 1 : (32'(count) > MAX_BOXES) ? MAX_BOXES : 32'(count);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_noise();
    logic [KIND_W-1:0]  kind;
    logic [LABEL_W-1:0] a;
    kind = KIND_W'($urandom_range(REQ_LEFT, REQ_SWAP));
    case ($urandom_range(0, 3))
      0: push_req($urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO, any_label(),
                  any_label());
      1: begin
        if ($urandom_range(0, 1)) push_req(kind, bad_label(), good_label());
        else push_req(kind, good_label(), bad_label());
      end
      2: begin
        a = good_label();
        push_req(kind, a, a);
      end
      default: push_req(REQ_INIT, any_label(), any_label());
    endcase
  endtask

  task automatic run_phase(input logic [COUNT_W-1:0] count, input int items,
                           input int tx_pct, input int rx_pct, input bit fresh,
                           input bit pressure);
    int                roll;
    logic [KIND_W-1:0] kind;
    set_count(count);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (fresh) push_req(REQ_INIT, any_label(), any_label());
    for (int i = 0; i < items; i++) begin
      if (pressure && i == items / 4) rx_hold_req = 400;
      if (pressure && i == items / 2) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        push_req(REQ_REVERSE, any_label(), any_label());
      end else if (roll < 22) begin
        push_req(REQ_REPORT, any_label(), any_label());
      end else if (roll < 32) begin
        push_noise();
      end else begin
        kind = KIND_W'($urandom_range(REQ_LEFT, REQ_SWAP));
        push_req(kind, good_label(), good_label());
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_INIT;
    final_check   = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    rx_hold_req   = 0;
    hold_left     = 0;
    reports_sent  = 0;
    results_seen  = 0;
    cycle_count   = 0;
    eff_n         = MAX_BOXES;
    inited_upto   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full list at the reset count, both orientations
    push_req(REQ_INIT, '0, '0);
    push_req(REQ_REPORT, '0, '0);
    push_req(REQ_REVERSE, '0, '0);
    push_req(REQ_REPORT, '0, '0);

    set_count(11'd6);
    push_req(REQ_INIT, 11'd2047, 11'd2047);
    push_req(REQ_LEFT, 11'd1, 11'd2);
    push_req(REQ_RIGHT, 11'd3, 11'd2);
    push_req(REQ_SWAP, 11'd3, 11'd4);
    push_req(REQ_SWAP, 11'd5, 11'd3);
    push_req(REQ_SWAP, 11'd1, 11'd6);
    push_req(REQ_LEFT, 11'd5, 11'd2);
    push_req(REQ_RIGHT, 11'd1, 11'd4);
    push_req(REQ_REPORT, '0, '0);
    push_req(REQ_REVERSE, '0, '0);
    push_req(REQ_LEFT, 11'd6, 11'd1);
    push_req(REQ_RIGHT, 11'd2, 11'd3);
    push_req(REQ_REPORT, '0, '0);
    push_req(REQ_LEFT, 11'd0, 11'd3);
    push_req(REQ_SWAP, 11'd2, 11'd7);
    push_req(REQ_RIGHT, 11'd2047, 11'd2047);
    push_req(REQ_SWAP, 11'd4, 11'd4);
    push_req(KIND_SPARE_LO, 11'd1, 11'd2);
    push_req(KIND_SPARE_HI, 11'd2047, 11'd1024);
    push_req(REQ_REPORT, 11'd2047, 11'd2047);

    run_phase(11'd16,   250,  0,  0, 1'b1, 1'b0);
    run_phase(11'd2,    150, 55,  0, 1'b1, 1'b0);
    run_phase(11'd0,     60,  0, 55, 1'b1, 1'b0);
    run_phase(11'd40,   250, 36, 36, 1'b1, 1'b0);
    run_phase(11'd7,    200,  0, 55, 1'b1, 1'b1);
    run_phase(11'd3,    120, 55,  0, 1'b1, 1'b0);
    run_phase(11'd1024,  40,  0,  0, 1'b1, 1'b0);
    // count changes with no fresh init: the walk follows the old links
    run_phase(11'd2047,  20, 36, 36, 1'b0, 1'b0);
    run_phase(11'd12,   150, 36, 36, 1'b0, 1'b0);
    run_phase(11'd1025,  30, 55,  0, 1'b0, 1'b0);
    run_phase(11'd25,   250,  0, 55, 1'b1, 1'b0);
    run_phase(11'd5,    200, 36, 36, 1'b1, 1'b0);
    run_phase(11'd9,    180,  0,  0, 1'b1, 1'b0);

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    final_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("linked_list_box_reorder_tb: clean");
    end else begin
      $display("linked_list_box_reorder_tb: errors");
    end
    $finish;
  end

endmodule

// ===== linked_list_box_reorder.f =====
design/lbr_pkg.sv
design/lbr_link_ram.sv
design/linked_list_box_reorder.sv
dv/lbr_list_checker.sv
dv/linked_list_box_reorder_tb.sv
